// ----- rtl/ttsb_pkg.sv -----
// Package: shared constants, types and state codes for the terminal scroll buffer.
`timescale 1ns / 1ps

package ttsb_pkg;

  localparam int ROWS   = 5;
  localparam int COLS   = 21;
  localparam int CELLS  = ROWS * COLS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS + 1);
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scroll;
    logic sweep_last;
    logic is_read;
  } dp_status_t;

endpackage

// ----- rtl/text_terminal_scroll_buffer_core.sv -----
// Terminal character grid with cursor and scroll: top level.
// Flow: each transaction is accepted, executed and its result loaded; a line feed on the
//   last row also zero-fills the new bottom row through the one write port before the load.
// One transaction at a time: no new one is accepted until its result is loaded, and a
//   result held by out_stall_i holds off that load, and so the next transaction.
// Reset: cursor home, packet skip off, every cell reads 1 through per-cell valid bits.
`timescale 1ns / 1ps

module text_terminal_scroll_buffer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_packet_i,
  input  logic [2:0] read_row_i,
  input  logic [4:0] read_col_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_char_o,
  output logic [4:0] cursor_col_o,
  output logic [2:0] cursor_row_o
);

  ttsb_pkg::ctrl_cmd_t  cmd;
  ttsb_pkg::dp_status_t sts;

  ttsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ttsb_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .command_i       (command_i),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .read_row_i      (read_row_i),
    .read_col_i      (read_col_i),
    .read_char_o     (read_char_o),
    .cursor_col_o    (cursor_col_o),
    .cursor_row_o    (cursor_row_o)
  );

  // one transaction in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("transaction accepted while another is in flight");

  // byte transactions always return a zero character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out && !sts.is_read) |=> (read_char_o == 8'd0))
    else $error("nonzero read_char for a byte transaction");

  // result load never overwrites a result still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(cursor_row_o) < ttsb_pkg::ROWS))
    else $error("cursor row out of range");

endmodule

// ----- rtl/ttsb_ctrl.sv -----
// Controller: sequences one transaction through execute, row fill and result push.
`timescale 1ns / 1ps

module ttsb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  ttsb_pkg::dp_status_t sts_i,
  output ttsb_pkg::ctrl_cmd_t cmd_o
);

  ttsb_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttsb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ttsb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ttsb_pkg::ST_EXEC;
        end
      end
      ttsb_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.scroll ? ttsb_pkg::ST_SWEEP : ttsb_pkg::ST_PUSH;
      end
      ttsb_pkg::ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ttsb_pkg::ST_PUSH;
        end
      end
      ttsb_pkg::ST_PUSH: begin
        // output register free, or being emptied this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ttsb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ttsb_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ttsb_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/ttsb_datapath.sv -----
// Datapath: item registers, cursor, rotating row base, character memory, result registers.
`timescale 1ns / 1ps

module ttsb_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ttsb_pkg::ctrl_cmd_t  cmd_i,
  output ttsb_pkg::dp_status_t sts_o,
  input  logic                 command_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_packet_i,
  input  logic [2:0]           read_row_i,
  input  logic [4:0]           read_col_i,
  output logic [7:0]           read_char_o,
  output logic [4:0]           cursor_col_o,
  output logic [2:0]           cursor_row_o
);

  localparam int RW = ttsb_pkg::ROW_W;
  localparam int CW = ttsb_pkg::COL_W;
  localparam int AW = ttsb_pkg::ADDR_W;

  // logical row to physical row under the rotating base
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lr,
                                             input logic [RW-1:0] base);
    logic [RW:0] s;
    s = {1'b0, lr} + {1'b0, base};
    if (s >= (RW + 1)'(ttsb_pkg::ROWS)) begin
      s = s - (RW + 1)'(ttsb_pkg::ROWS);
    end
    return s[RW-1:0];
  endfunction

  // captured transaction
  logic       cmd_q;
  logic [7:0] byte_q;
  logic       eop_q;
  logic [2:0] rrow_q;
  logic [4:0] rcol_q;

  // control state
  logic [CW-1:0]              col_q, col_d;
  logic [RW-1:0]              row_q, row_d;
  logic [RW-1:0]              base_q, base_d;
  logic                       skip_q, skip_d;
  logic [RW-1:0]              sweep_row_q, sweep_row_d;
  logic [CW-1:0]              sweep_col_q, sweep_col_d;
  logic [ttsb_pkg::CELLS-1:0] vld_q, vld_d;

  // memory and read path
  logic [7:0] mem_q [ttsb_pkg::CELLS];
  logic [7:0] rd_data_q;
  logic       rd_vld_q;
  logic       rd_ok_q;

  // result registers
  logic [7:0] read_char_q;
  logic [4:0] cursor_col_q;
  logic [2:0] cursor_row_q;

  logic          active, is_hash, is_lf, is_cr, is_print;
  logic          row_last, col_lt, rd_ok;
  logic          we, re;
  logic [AW-1:0] cur_addr, rd_addr, sw_addr, wa;
  logic [7:0]    wd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= command_i;
      byte_q <= data_byte_i;
      eop_q  <= end_of_packet_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
  end

  always_comb begin
    active   = (cmd_q == ttsb_pkg::CMD_BYTE) && !skip_q;
    is_hash  = active && (byte_q == ttsb_pkg::CH_HASH);
    is_lf    = active && (byte_q == ttsb_pkg::CH_LF);
    is_cr    = active && (byte_q == ttsb_pkg::CH_CR);
    is_print = active && !is_hash && !is_lf && !is_cr;
    row_last = (row_q == RW'(ttsb_pkg::ROWS - 1));
    col_lt   = (32'(col_q) < ttsb_pkg::COLS);
    rd_ok    = (32'(rrow_q) < ttsb_pkg::ROWS) && (32'(rcol_q) < ttsb_pkg::COLS);

    cur_addr = AW'(phys_row(row_q, base_q)) * AW'(ttsb_pkg::COLS) + AW'(col_q);
    rd_addr  = rd_ok ? AW'(phys_row(RW'(rrow_q), base_q)) * AW'(ttsb_pkg::COLS)
                       + AW'(rcol_q) : '0;
    sw_addr  = AW'(sweep_row_q) * AW'(ttsb_pkg::COLS) + AW'(sweep_col_q);

    we = (cmd_i.exec && is_print && col_lt) || cmd_i.sweep_step;
    wa = cmd_i.sweep_step ? sw_addr : cur_addr;
    wd = cmd_i.sweep_step ? 8'd0 : byte_q;
    re = cmd_i.exec && (cmd_q == ttsb_pkg::CMD_READ);

    sts_o.scroll     = is_lf && row_last;
    sts_o.sweep_last = (sweep_col_q == CW'(ttsb_pkg::COLS - 1));
    sts_o.is_read    = (cmd_q == ttsb_pkg::CMD_READ);
  end

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    base_d      = base_q;
    skip_d      = skip_q;
    sweep_row_d = sweep_row_q;
    sweep_col_d = sweep_col_q;
    vld_d       = vld_q;
    if (cmd_i.exec && (cmd_q == ttsb_pkg::CMD_BYTE)) begin
      if (skip_q) begin
        if (eop_q) begin
          skip_d = 1'b0;
        end
      end else if (is_hash) begin
        // cells not valid read back as 1
        vld_d  = '0;
        col_d  = '0;
        row_d  = '0;
        skip_d = !eop_q;
      end else if (is_lf) begin
        if (row_last) begin
          // old top row becomes the new bottom row, zero-filled by the sweep
          base_d      = (base_q == RW'(ttsb_pkg::ROWS - 1)) ? '0 : base_q + 1'b1;
          sweep_row_d = base_q;
          sweep_col_d = '0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else if (is_cr) begin
        col_d = '0;
      end else if (col_lt) begin
        col_d = col_q + 1'b1;
      end
    end
    if (cmd_i.sweep_step) begin
      sweep_col_d = sweep_col_q + 1'b1;
    end
    if (we) begin
      vld_d[wa] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      skip_q      <= 1'b0;
      sweep_row_q <= '0;
      sweep_col_q <= '0;
      vld_q       <= '0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      base_q      <= base_d;
      skip_q      <= skip_d;
      sweep_row_q <= sweep_row_d;
      sweep_col_q <= sweep_col_d;
      vld_q       <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_vld_q <= vld_q[rd_addr];
      rd_ok_q  <= rd_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if ((cmd_q == ttsb_pkg::CMD_READ) && rd_ok_q) begin
        read_char_q <= rd_vld_q ? rd_data_q : 8'd1;
      end else begin
        read_char_q <= 8'd0;
      end
      cursor_col_q <= 5'(col_q);
      cursor_row_q <= 3'(row_q);
    end
  end

  assign read_char_o  = read_char_q;
  assign cursor_col_o = cursor_col_q;
  assign cursor_row_o = cursor_row_q;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the terminal scroll buffer core.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] ch;
    logic [4:0] col;
    logic [2:0] row;
  } readout_t;

  // Predicts the grid, cursor and packet-drop flag; holds expected readouts.
  class scroll_scoreboard;
    logic [7:0] grid_cells [ttsb_pkg::ROWS][ttsb_pkg::COLS];
    int unsigned cur_col;
    int unsigned cur_row;
    bit dropping_packet;
    readout_t expected_readouts[$];
    int mismatches;

    function new();
      clear_screen();
      dropping_packet = 1'b0;
      mismatches = 0;
    endfunction

    function void clear_screen();
      foreach (grid_cells[r, c]) grid_cells[r][c] = 8'd1;
      cur_col = 0;
      cur_row = 0;
    endfunction

    // Returns 0 when the byte is swallowed by a dropped packet.
    function bit record_transaction(logic cmd, logic [7:0] b, logic eop,
                                    logic [2:0] rr, logic [4:0] rc);
      readout_t exp_out;
      bit counted;
      exp_out = '0;
      counted = 1'b1;
      if (cmd == ttsb_pkg::CMD_READ) begin
        if (rr < ttsb_pkg::ROWS && rc < ttsb_pkg::COLS) exp_out.ch = grid_cells[rr][rc];
      end else if (dropping_packet) begin
        if (eop) dropping_packet = 1'b0;
        counted = 1'b0;
      end else if (b == ttsb_pkg::CH_HASH) begin
        clear_screen();
        dropping_packet = !eop;
      end else if (b == ttsb_pkg::CH_LF) begin
        if (cur_row + 1 < ttsb_pkg::ROWS) begin
          cur_row++;
        end else begin
          for (int r = 0; r < ttsb_pkg::ROWS - 1; r++) grid_cells[r] = grid_cells[r + 1];
          for (int c = 0; c < ttsb_pkg::COLS; c++) grid_cells[ttsb_pkg::ROWS - 1][c] = 8'd0;
        end
      end else if (b == ttsb_pkg::CH_CR) begin
        cur_col = 0;
      end else if (cur_col < ttsb_pkg::COLS) begin
        grid_cells[cur_row][cur_col] = b;
        cur_col++;
      end
      exp_out.col = cur_col[4:0];
      exp_out.row = cur_row[2:0];
      expected_readouts.push_back(exp_out);
      return counted;
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      $display("tb: mismatch on %s: got %0d, want %0d", what, got, want);
    endtask

    task check_readout(logic [7:0] ch, logic [4:0] col, logic [2:0] row);
      readout_t want;
      if (expected_readouts.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = expected_readouts.pop_front();
        if (ch !== want.ch) report_mismatch("read_char", int'(ch), int'(want.ch));
        if (col !== want.col) report_mismatch("cursor_col", int'(col), int'(want.col));
        if (row !== want.row) report_mismatch("cursor_row", int'(row), int'(want.row));
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       command_i = ttsb_pkg::CMD_BYTE;
  logic [7:0] data_byte_i = 8'd0;
  logic       end_of_packet_i = 1'b0;
  logic [2:0] read_row_i = 3'd0;
  logic [4:0] read_col_i = 5'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] read_char_o;
  logic [4:0] cursor_col_o;
  logic [2:0] cursor_row_o;

  scroll_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_on = 1'b0;
  int accepted_items = 0;
  int cycle_count = 0;

  text_terminal_scroll_buffer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .read_row_i     (read_row_i),
    .read_col_i     (read_col_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_char_o    (read_char_o),
    .cursor_col_o   (cursor_col_o),
    .cursor_row_o   (cursor_row_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_readout(read_char_o, cursor_col_o, cursor_row_o);
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] b, input logic eop,
                           input logic [2:0] rr, input logic [4:0] rc);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    data_byte_i     <= b;
    end_of_packet_i <= eop;
    read_row_i      <= rr;
    read_col_i      <= rc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (sb.record_transaction(cmd, b, eop, rr, rc)) accepted_items++;
  endtask

  // Unused read fields carry random bits.
  task automatic send_byte(input logic [7:0] b, input logic eop);
    send_item(ttsb_pkg::CMD_BYTE, b, eop, 3'($urandom_range(7)), 5'($urandom_range(31)));
  endtask

  // Unused byte fields carry random bits.
  task automatic send_read(input logic [2:0] rr, input logic [4:0] rc);
    send_item(ttsb_pkg::CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), rr, rc);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_readouts.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_traffic(input int count);
    int target;
    int kind;
    int len;
    logic [7:0] b;
    logic [7:0] line_bytes[$];
    target = accepted_items + count;
    while (accepted_items < target) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        // text line, long enough at times to run past the row end
        line_bytes = {};
        len = $urandom_range(26);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(19) == 0) begin
            b = 8'($urandom_range(255));
          end else begin
            b = 8'($urandom_range(32, 126));
            if (b == ttsb_pkg::CH_HASH) b = "H";
          end
          line_bytes.push_back(b);
        end
        case ($urandom_range(3))
          0: begin
            line_bytes.push_back(ttsb_pkg::CH_CR);
            line_bytes.push_back(ttsb_pkg::CH_LF);
          end
          1: line_bytes.push_back(ttsb_pkg::CH_LF);
          2: line_bytes.push_back(ttsb_pkg::CH_CR);
          default: ;
        endcase
        foreach (line_bytes[i]) begin
          send_byte(line_bytes[i], (i == line_bytes.size() - 1) || ($urandom_range(7) == 0));
          if ($urandom_range(3) == 0) send_read(3'($urandom_range(ttsb_pkg::ROWS - 1)),
                                                5'($urandom_range(ttsb_pkg::COLS - 1)));
        end
      end else if (kind < 65) begin
        // packet with a clear in it; the tail is dropped unless the clear ends it
        repeat ($urandom_range(3)) send_byte(8'($urandom_range(32, 126)), 1'b0);
        send_byte(ttsb_pkg::CH_HASH, 1'($urandom_range(1)));
        len = $urandom_range(4);
        for (int i = 0; i < len; i++) begin
          send_byte(8'($urandom_range(255)), i == len - 1);
          if ($urandom_range(3) == 0) send_read(3'($urandom_range(7)), 5'($urandom_range(31)));
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(4) != 0) send_read(3'($urandom_range(ttsb_pkg::ROWS - 1)),
                                                5'($urandom_range(ttsb_pkg::COLS - 1)));
          else send_read(3'($urandom_range(7)), 5'($urandom_range(31)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                    3'($urandom_range(7)), 5'($urandom_range(31)));
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 84;

    // reset contents and out-of-range reads
    send_read(3'd0, 5'd0);
    send_read(3'(ttsb_pkg::ROWS - 1), 5'(ttsb_pkg::COLS - 1));
    send_read(3'd7, 5'd31);
    send_read(3'(ttsb_pkg::ROWS), 5'd0);
    send_read(3'd0, 5'(ttsb_pkg::COLS));
    // byte extremes, then cursor movement with a scroll from the last row
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte("A", 1'b1);
    send_read(3'd0, 5'd0);
    send_read(3'd0, 5'd1);
    send_byte(ttsb_pkg::CH_CR, 1'b0);
    repeat (ttsb_pkg::ROWS) send_byte(ttsb_pkg::CH_LF, 1'b0);
    send_read(3'(ttsb_pkg::ROWS - 1), 5'd0);
    send_read(3'd0, 5'd0);
    // clear mid-packet drops the tail; reads during the drop are served
    send_byte(ttsb_pkg::CH_HASH, 1'b0);
    send_byte("x", 1'b0);
    send_read(3'd0, 5'd0);
    send_byte("y", 1'b1);
    // clear that ends its own packet drops nothing
    send_byte(ttsb_pkg::CH_HASH, 1'b1);
    send_byte("z", 1'b1);
    send_read(3'd0, 5'd0);

    random_traffic(250);
    wait_drained();
    random_traffic(250);

    send_idle_pct = 84;
    recv_idle_pct = 38;
    random_traffic(500);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(200);
    // long receiver hold while items keep coming, to back up the input side
    @(posedge clk_i);
    hold_on = 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_on = 1'b0;
      end
    join_none
    random_traffic(40);
    random_traffic(160);

    wait_drained();
    repeat (ttsb_pkg::COLS + 10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_readouts.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
